// File: src/seeded_list_shuffler_assert.svh
// assertion macros for the shuffler, sampled on clk_i with rst_ni low as reset
`ifndef SEEDED_LIST_SHUFFLER_ASSERT_SVH
`define SEEDED_LIST_SHUFFLER_ASSERT_SVH

// same-cycle implication
`define SLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sls_pkg.sv
package sls_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam logic [63:0] SEED_SALT   = 64'h243f6a8885a308d3;
  localparam int unsigned SHIFT_A     = 30;
  localparam int unsigned SHIFT_B     = 27;
  localparam int unsigned SHIFT_C     = 31;
  localparam int unsigned OUT_BITS    = 16;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_GEN,
    OP_MULA,
    OP_FOLD,
    OP_MULB,
    OP_FINISH,
    OP_DIV,
    OP_RDA,
    OP_RDB,
    OP_WRA,
    OP_WRB,
    OP_EINIT,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic short_list;
    logic mul_done;
    logic div_done;
    logic r_done;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// File: src/seeded_list_shuffler.sv
// seeded list shuffler
// the input stream carries list elements, tlast on the final one; elements
// past LIST_DEPTH are dropped and every result of that list has tuser set
// on tlast the stored list is shuffled with a backward fisher-yates pass,
// each swap index a splitmix64 output modulo the remaining count, the
// generator starting from shuffle_seed xor a fixed salt for every list
// the output stream then gives the shuffled list in order, tlast on its end
// loading takes one element per cycle; each swap steps the generator, runs two
// multiplies of three partial products, each followed by a fold, a bit-serial
// modulo and two memory reads and two writes, the modulo unit setting the pace;
// each result is read from the memory and then loaded into a single output register
// no request is accepted from the shuffle until the last result is loaded
// into the output register; a stalled receiver holds that register and
// halts emission
// reset clears the seed, the element count, the overflow flag and the
// output valid; the element memory is not cleared
// seed writes take effect at the next shuffle; the user must make them while idle, the block does not enforce it
`include "seeded_list_shuffler_assert.svh"

module seeded_list_shuffler #(
  parameter int unsigned LIST_DEPTH   = 64,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // seed register
  input  logic        shuffle_seed_we_i,
  input  logic [63:0] shuffle_seed_wdata_i,
  // element requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] element
  input  logic        s_axis_tlast_i,
  // shuffled results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] out_element
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o   // [0] overflow
);

  sls_pkg::cmd_t cmd;
  sls_pkg::sts_t sts;

  // sequencer: load, per-swap generator and modulo steps, emission
  sls_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tready_o(s_axis_tready_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // element memory, generator, multiplier, modulo unit and output register
  sls_dp #(
    .LIST_DEPTH  (LIST_DEPTH),
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .shuffle_seed_we_i   (shuffle_seed_we_i),
    .shuffle_seed_wdata_i(shuffle_seed_wdata_i),
    .s_axis_tdata_i      (s_axis_tdata_i),
    .m_axis_tready_i     (m_axis_tready_i),
    .m_axis_tvalid_o     (m_axis_tvalid_o),
    .m_axis_tdata_o      (m_axis_tdata_o),
    .m_axis_tlast_o      (m_axis_tlast_o),
    .m_axis_tuser_o      (m_axis_tuser_o)
  );

  // a store only happens on a real input handshake
  `SLS_ASSERT_NOW(a_load_on_req, cmd.op == sls_pkg::OP_LOAD, s_axis_tvalid_i && s_axis_tready_o, "load without request")
  // a result is never written over one still waiting
  `SLS_ASSERT_NOW(a_emit_free, cmd.op == sls_pkg::OP_EMIT, !m_axis_tvalid_o || m_axis_tready_i, "result overwritten")
  // after the last result is loaded the block takes requests again
  `SLS_ASSERT_NEXT(a_back_to_in, cmd.op == sls_pkg::OP_EMIT && sts.emit_last, s_axis_tready_o && m_axis_tvalid_o && m_axis_tlast_o, "no return to load")

endmodule

// File: src/sls_ram.sv
module sls_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/sls_ctrl.sv
module sls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  input  logic          s_axis_tlast_i,
  output logic          s_axis_tready_o,
  input  sls_pkg::sts_t sts_i,
  output sls_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IN    = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_GEN   = 4'd2;
  localparam logic [3:0] S_MA    = 4'd3;
  localparam logic [3:0] S_FA    = 4'd4;
  localparam logic [3:0] S_MB    = 4'd5;
  localparam logic [3:0] S_FB    = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_RA    = 4'd8;
  localparam logic [3:0] S_RB    = 4'd9;
  localparam logic [3:0] S_WA    = 4'd10;
  localparam logic [3:0] S_WB    = 4'd11;
  localparam logic [3:0] S_EINIT = 4'd12;
  localparam logic [3:0] S_ERD   = 4'd13;
  localparam logic [3:0] S_ELD   = 4'd14;

  logic [3:0] state_q, state_d;

  assign s_axis_tready_o = (state_q == S_IN);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = sls_pkg::OP_NONE;
    unique case (state_q)
      S_IN: begin
        if (s_axis_tvalid_i) begin
          cmd_o.op = sls_pkg::OP_LOAD;
          if (s_axis_tlast_i) state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.op = sls_pkg::OP_START;
        state_d  = sts_i.short_list ? S_EINIT : S_GEN;
      end
      S_GEN: begin
        cmd_o.op = sls_pkg::OP_GEN;
        state_d  = S_MA;
      end
      S_MA: begin
        cmd_o.op = sls_pkg::OP_MULA;
        if (sts_i.mul_done) state_d = S_FA;
      end
      S_FA: begin
        cmd_o.op = sls_pkg::OP_FOLD;
        state_d  = S_MB;
      end
      S_MB: begin
        cmd_o.op = sls_pkg::OP_MULB;
        if (sts_i.mul_done) state_d = S_FB;
      end
      S_FB: begin
        cmd_o.op = sls_pkg::OP_FINISH;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = sls_pkg::OP_DIV;
        if (sts_i.div_done) state_d = S_RA;
      end
      S_RA: begin
        cmd_o.op = sls_pkg::OP_RDA;
        state_d  = S_RB;
      end
      S_RB: begin
        cmd_o.op = sls_pkg::OP_RDB;
        state_d  = S_WA;
      end
      S_WA: begin
        cmd_o.op = sls_pkg::OP_WRA;
        state_d  = S_WB;
      end
      S_WB: begin
        cmd_o.op = sls_pkg::OP_WRB;
        state_d  = sts_i.r_done ? S_EINIT : S_GEN;
      end
      S_EINIT: begin
        cmd_o.op = sls_pkg::OP_EINIT;
        state_d  = S_ERD;
      end
      S_ERD: begin
        state_d = S_ELD;
      end
      S_ELD: begin
        if (sts_i.out_free) begin
          cmd_o.op = sls_pkg::OP_EMIT;
          state_d  = sts_i.emit_last ? S_IN : S_ERD;
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/sls_dp.sv
module sls_dp #(
  parameter int unsigned LIST_DEPTH   = 64,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sls_pkg::cmd_t cmd_i,
  output sls_pkg::sts_t sts_o,
  input  logic          shuffle_seed_we_i,
  input  logic [63:0]   shuffle_seed_wdata_i,
  input  logic [15:0]   s_axis_tdata_i,
  input  logic          m_axis_tready_i,
  output logic          m_axis_tvalid_o,
  output logic [15:0]   m_axis_tdata_o,
  output logic          m_axis_tlast_o,
  output logic          m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic [63:0]   seed_q;
  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic          ovalid_q;
  logic [15:0]   odata_q;
  logic          olast_q;
  logic          ouser_q;

  logic [63:0]   gen_q, x_q, acc_q, g_q;
  logic [CW-1:0] rem_q, r_q;
  logic [5:0]    dcnt_q;
  logic [1:0]    ph_q;
  logic [AW-1:0] k_q;
  logic [ELEMENT_BITS-1:0] t_q;

  // ram ports
  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [ELEMENT_BITS-1:0] wdata, rdata;
  logic [63:0]             in_ext, rd_ext;
  logic [CW-1:0]           rm1;
  logic [AW-1:0]           j_idx;

  sls_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(LIST_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_ext = 64'(s_axis_tdata_i);
  assign rd_ext = 64'(rdata);
  assign rm1    = r_q - CW'(1);
  assign j_idx  = rem_q[AW-1:0];

  logic room;
  assign room = (count_q < CW'(LIST_DEPTH));

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = in_ext[ELEMENT_BITS-1:0];
    raddr = k_q;
    unique case (cmd_i.op)
      sls_pkg::OP_LOAD: we = room;
      sls_pkg::OP_RDA:  raddr = rm1[AW-1:0];
      sls_pkg::OP_RDB:  raddr = j_idx;
      sls_pkg::OP_WRA: begin
        we    = 1'b1;
        waddr = rm1[AW-1:0];
        wdata = rdata;
      end
      sls_pkg::OP_WRB: begin
        we    = 1'b1;
        waddr = j_idx;
        wdata = t_q;
      end
      default: ;
    endcase
  end

  // 64x64 low-half product over three 32x32 partial products
  logic [31:0] ma, mb;
  logic [63:0] mp, mconst;
  assign mconst = (cmd_i.op == sls_pkg::OP_MULB) ? sls_pkg::MIX_MUL_B : sls_pkg::MIX_MUL_A;
  always_comb begin
    unique case (ph_q)
      2'd0:    begin ma = x_q[31:0];  mb = mconst[31:0];  end
      2'd1:    begin ma = x_q[31:0];  mb = mconst[63:32]; end
      default: begin ma = x_q[63:32]; mb = mconst[31:0];  end
    endcase
  end
  assign mp = ma * mb;

  // one restoring division step per cycle
  logic [CW:0]   shifted;
  logic [CW-1:0] rem_next;
  assign shifted  = {rem_q, g_q[63]};
  assign rem_next = (shifted >= {1'b0, r_q}) ? CW'(shifted - {1'b0, r_q}) : shifted[CW-1:0];

  logic [63:0] gen_step;
  assign gen_step = gen_q + sls_pkg::GOLDEN_STEP;

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready_i;

  assign sts_o.short_list = (count_q < CW'(2));
  assign sts_o.mul_done   = (ph_q == 2'd2);
  assign sts_o.div_done   = (dcnt_q == 6'd63);
  assign sts_o.r_done     = (r_q == CW'(2));
  assign sts_o.emit_last  = ((CW'(k_q) + CW'(1)) == count_q);
  assign sts_o.out_free   = out_free;

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = ouser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (shuffle_seed_we_i) seed_q <= shuffle_seed_wdata_i;
      if (cmd_i.op == sls_pkg::OP_LOAD) begin
        if (room) count_q <= count_q + CW'(1);
        else      ovf_q   <= 1'b1;
      end
      if (cmd_i.op == sls_pkg::OP_EMIT) begin
        ovalid_q <= 1'b1;
        if (sts_o.emit_last) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      sls_pkg::OP_START: begin
        gen_q <= seed_q ^ sls_pkg::SEED_SALT;
        r_q   <= count_q;
      end
      sls_pkg::OP_GEN: begin
        gen_q <= gen_step;
        x_q   <= gen_step ^ (gen_step >> sls_pkg::SHIFT_A);
        ph_q  <= 2'd0;
      end
      sls_pkg::OP_MULA, sls_pkg::OP_MULB: begin
        if (ph_q == 2'd0) acc_q <= mp;
        else              acc_q[63:32] <= acc_q[63:32] + mp[31:0];
        ph_q <= ph_q + 2'd1;
      end
      sls_pkg::OP_FOLD: begin
        x_q  <= acc_q ^ (acc_q >> sls_pkg::SHIFT_B);
        ph_q <= 2'd0;
      end
      sls_pkg::OP_FINISH: begin
        g_q    <= acc_q ^ (acc_q >> sls_pkg::SHIFT_C);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      sls_pkg::OP_DIV: begin
        rem_q  <= rem_next;
        g_q    <= {g_q[62:0], 1'b0};
        dcnt_q <= dcnt_q + 6'd1;
      end
      sls_pkg::OP_RDB: t_q <= rdata;
      sls_pkg::OP_WRB: r_q <= rm1;
      sls_pkg::OP_EINIT: k_q <= '0;
      sls_pkg::OP_EMIT: begin
        odata_q <= rd_ext[15:0];
        olast_q <= sts_o.emit_last;
        ouser_q <= ovf_q;
        k_q     <= k_q + AW'(1);
      end
      default: ;
    endcase
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// checks the seeded list shuffler end to end
// lists of elements are sent on the input stream; a local splitmix64 plus
// fisher-yates predictor builds the shuffled list for each one, and every
// output request is compared with the oldest predicted element
// phases cover reset seed, extreme seeds, an overflowing store,
// random idling on both sides and a long receiver hold-off

module testbench;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] element;
    logic        last;
    logic        overflow;
  } shuffled_t;

  logic        clk_i;
  logic        rst_ni;
  logic        seed_we;
  logic [63:0] seed_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_data;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_data;
  logic        out_last;
  logic        out_user;

  seeded_list_shuffler dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .shuffle_seed_we_i    (seed_we),
    .shuffle_seed_wdata_i (seed_wdata),
    .s_axis_tvalid_i      (in_valid),
    .s_axis_tready_o      (in_ready),
    .s_axis_tdata_i       (in_data),
    .s_axis_tlast_i       (in_last),
    .m_axis_tvalid_o      (out_valid),
    .m_axis_tready_i      (out_ready),
    .m_axis_tdata_o       (out_data),
    .m_axis_tlast_o       (out_last),
    .m_axis_tuser_o       (out_user)
  );

  // predictor state
  logic [63:0] seed_model;
  logic [15:0] list_model [DEPTH];
  int unsigned list_len;
  logic        list_ovf;
  logic [63:0] gen_state;
  shuffled_t   shuffled_q [$];

  // idling knobs
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_cycles;
  int unsigned errors;
  int unsigned idle_count;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // splitmix64 step on the predictor's generator
  function automatic logic [63:0] next_random();
    logic [63:0] z;
    gen_state = gen_state + sls_pkg::GOLDEN_STEP;
    z = gen_state;
    z = (z ^ (z >> sls_pkg::SHIFT_A)) * sls_pkg::MIX_MUL_A;
    z = (z ^ (z >> sls_pkg::SHIFT_B)) * sls_pkg::MIX_MUL_B;
    return z ^ (z >> sls_pkg::SHIFT_C);
  endfunction

  // store one accepted element; on the list end shuffle and queue the results
  function automatic void predict_element(logic [15:0] element, logic last);
    logic [63:0] pick;
    logic [15:0] tmp;
    shuffled_t   res;
    if (list_len < DEPTH) begin
      list_model[list_len] = element;
      list_len++;
    end else begin
      list_ovf = 1'b1;
    end
    if (!last) return;
    gen_state = seed_model ^ sls_pkg::SEED_SALT;
    for (int unsigned r = list_len; r > 1; r--) begin
      pick = next_random() % 64'(r);
      tmp = list_model[r - 1];
      list_model[r - 1] = list_model[pick];
      list_model[pick] = tmp;
    end
    for (int unsigned k = 0; k < list_len; k++) begin
      res.element = list_model[k];
      res.last = (k + 1 == list_len);
      res.overflow = list_ovf;
      shuffled_q = {shuffled_q, res};
    end
    list_len = 0;
    list_ovf = 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one element request, with random idle cycles in front
  task automatic send_element(logic [15:0] element, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = element;
    in_last  = last;
    do @(posedge clk_i); while (!in_ready);
    predict_element(element, last);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic send_list(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_element(16'($urandom), i + 1 == len);
  endtask

  // wait for every predicted result, then let the block settle
  task automatic wait_drained();
    while (shuffled_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_seed(logic [63:0] value);
    seed_we    = 1'b1;
    seed_wdata = value;
    @(negedge clk_i);
    seed_we    = 1'b0;
    seed_model = value;
  endtask

  // receiver side: random stalls, or a long hold-off counted down here
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    shuffled_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (shuffled_q.size() == 0) begin
        report_mismatch("unexpected result", out_data, 16'h0000);
      end else begin
        want = shuffled_q.pop_front();
        if (out_data !== want.element) report_mismatch("element", out_data, want.element);
        if (out_last !== want.last) report_mismatch("tlast", 16'(out_last), 16'(want.last));
        if (out_user !== want.overflow)
          report_mismatch("overflow", 16'(out_user), 16'(want.overflow));
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // reset seed, one-element lists (no generator draw) and field extremes
  task automatic test_directed();
    send_element(16'h0000, 1'b1);
    send_element(16'hffff, 1'b1);
    send_element(16'h0001, 1'b0);
    send_element(16'h8000, 1'b1);
    send_element(16'h0000, 1'b0);
    send_element(16'hffff, 1'b0);
    send_element(16'haaaa, 1'b0);
    send_element(16'h5555, 1'b1);
    wait_drained();
  endtask

  // extreme and random seeds, each followed by short lists
  task automatic test_seeds();
    write_seed(64'hffff_ffff_ffff_ffff);
    send_list(5);
    wait_drained();
    write_seed(sls_pkg::SEED_SALT);
    send_list(4);
    wait_drained();
    write_seed({$urandom, $urandom});
    send_list(3);
    send_list(1);
    wait_drained();
  endtask

  // a list past the store size, then a short one with the flag cleared
  task automatic test_overflow();
    send_list(DEPTH + 1);
    wait_drained();
    write_seed(64'h0);
    send_list(3);
    wait_drained();
  endtask

  // mostly short random lists through every idling phase
  task automatic test_random();
    int unsigned tx_pct [4] = '{0, 48, 0, 19};
    int unsigned rx_pct [4] = '{0, 0, 48, 19};
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      write_seed({$urandom, $urandom});
      for (int n = 0; n < 5; n++)
        send_list(($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(5, 1));
      wait_drained();
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  // receiver held off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    @(negedge clk_i);
    hold_cycles = 600;
    send_list(6);
    send_list(5);
    while (shuffled_q.size() != 0) @(negedge clk_i);
    send_list(4);
    wait_drained();
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    seed_we      = 1'b0;
    seed_wdata   = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    in_last      = 1'b0;
    out_ready    = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_cycles  = 0;
    errors       = 0;
    idle_count   = 0;
    seed_model   = '0;
    list_len     = 0;
    list_ovf     = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_seeds();
    test_overflow();
    test_random();
    test_backpressure();

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: seeded_list_shuffler.f
+incdir+src
src/sls_pkg.sv
src/sls_ram.sv
src/sls_ctrl.sv
src/sls_dp.sv
src/seeded_list_shuffler.sv
dv/testbench.sv
